@@ src/v2cf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v2cf_pkg
// shared constants, register codes and types of the 2d correlation filter
// ----------------------------------------------------------------------------
package v2cf_pkg;

    localparam int MAX_KERNEL_DEF = 5;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int PIXEL_BITS_DEF = 16;

    localparam int MAX_HEIGHT   = 1024;
    localparam int COORD_BITS   = 10;
    localparam int SUM_BITS     = 36;
    localparam int CFG_BITS     = 11;
    localparam int CFG_IDX_BITS = 2;
    localparam int KSIZE_BITS   = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_KSIZE  = 2'd2
    } cfg_reg_t;

    localparam logic CMD_COEF  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    typedef struct packed {
        logic                  valid;
        logic [COORD_BITS-1:0] out_row;
        logic [COORD_BITS-1:0] out_col;
        logic                  frame_last;
    } res_meta_t;

endpackage

@@ src/v2cf_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v2cf_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module v2cf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/v2cf_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v2cf_mac
// window multiply and adder tree: products, row sums, total
// ----------------------------------------------------------------------------
module v2cf_mac
    import v2cf_pkg::*;
#(
    parameter int MAX_KERNEL = MAX_KERNEL_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF,
    parameter int KW         = $clog2(MAX_KERNEL + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  res_meta_t                    meta_in,
    input  logic [KW-1:0]                k_eff,
    input  logic signed [PIXEL_BITS-1:0] kernel [MAX_KERNEL*MAX_KERNEL],
    input  logic signed [PIXEL_BITS-1:0] window [MAX_KERNEL][MAX_KERNEL],
    output logic [SUM_BITS-1:0]          sum,
    output res_meta_t                    meta_out
);

    localparam int MK2    = MAX_KERNEL * MAX_KERNEL;
    localparam int CIDX_W = (MK2 > 1) ? $clog2(MK2) : 1;
    localparam int PROD_W = 2 * PIXEL_BITS;
    localparam int RAW_W  = PROD_W + ((MK2 > 1) ? $clog2(MK2) : 1);
    localparam int ACC_W  = (RAW_W > SUM_BITS) ? RAW_W : SUM_BITS;

    logic signed [PROD_W-1:0] prod_next [MAX_KERNEL][MAX_KERNEL];
    logic signed [PROD_W-1:0] prod_reg  [MAX_KERNEL][MAX_KERNEL];
    logic signed [ACC_W-1:0]  rsum_next [MAX_KERNEL];
    logic signed [ACC_W-1:0]  rsum_reg  [MAX_KERNEL];
    logic signed [ACC_W-1:0]  total_next;
    logic signed [ACC_W-1:0]  total_reg;
    res_meta_t                b_meta_reg;
    res_meta_t                c_meta_reg;
    res_meta_t                d_meta_reg;
    res_meta_t                e_meta_reg;

    // kernel position of every window cell for the kernel size in use
    always_comb
    begin
        int off;
        int idx;
        off = MAX_KERNEL - int'(k_eff);
        for (int r = 0; r < MAX_KERNEL; r++)
        begin
            for (int c = 0; c < MAX_KERNEL; c++)
            begin
                idx = (r - off) * int'(k_eff) + (c - off);
                if (r >= off && c >= off)
                begin
                    prod_next[r][c] = PROD_W'(kernel[CIDX_W'(idx)] * window[r][c]);
                end
                else
                begin
                    prod_next[r][c] = '0;
                end
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < MAX_KERNEL; r++)
        begin
            rsum_next[r] = '0;
            for (int c = 0; c < MAX_KERNEL; c++)
            begin
                rsum_next[r] = rsum_next[r] + ACC_W'(prod_reg[r][c]);
            end
        end
        total_next = '0;
        for (int r = 0; r < MAX_KERNEL; r++)
        begin
            total_next = total_next + rsum_reg[r];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_meta_reg <= '0;
            c_meta_reg <= '0;
            d_meta_reg <= '0;
            e_meta_reg <= '0;
        end
        else if (adv)
        begin
            b_meta_reg <= meta_in;
            c_meta_reg <= b_meta_reg;
            d_meta_reg <= c_meta_reg;
            e_meta_reg <= d_meta_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg  <= prod_next;
            rsum_reg  <= rsum_next;
            total_reg <= total_next;
        end
    end

    assign sum      = total_reg[SUM_BITS-1:0];
    assign meta_out = e_meta_reg;

endmodule

@@ src/valid_2d_correlation_filter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// valid_2d_correlation_filter_top
// streaming valid 2d cross-correlation with a square kernel of up to
// MAX_KERNEL by MAX_KERNEL, line buffers held in one ram
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_stall    cmd, coef_index, value
//   out      output     out_valid/out_stall  sum, out_row, out_col, frame_last
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// one transaction per clock on the input while in_stall is low; results pass
// stage a, the window register, then the product, row sum and total registers
// the line buffer ram is read at accept and written back from stage a when it advances;
// a same-column read and write in one cycle is forwarded
// a stalled result freezes the whole pipeline and raises in_stall
// asynchronous reset, no clearing pass; ram contents are undefined
// ----------------------------------------------------------------------------
module valid_2d_correlation_filter_top
    import v2cf_pkg::*;
#(
    parameter int MAX_KERNEL = MAX_KERNEL_DEF,
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_we,
    input  logic [CFG_IDX_BITS-1:0]                    cfg_index,
    input  logic [CFG_BITS-1:0]                        cfg_data,
    input  logic                                       in_valid,
    output logic                                       in_stall,
    input  logic                                       cmd,
    input  logic [((MAX_KERNEL*MAX_KERNEL > 1) ?
                   $clog2(MAX_KERNEL*MAX_KERNEL) : 1)-1:0] coef_index,
    input  logic signed [PIXEL_BITS-1:0]               value,
    output logic                                       out_valid,
    input  logic                                       out_stall,
    output logic signed [SUM_BITS-1:0]                 sum,
    output logic [COORD_BITS-1:0]                      out_row,
    output logic [COORD_BITS-1:0]                      out_col,
    output logic                                       frame_last
);

    localparam int MK2     = MAX_KERNEL * MAX_KERNEL;
    localparam int CIDX_W  = (MK2 > 1) ? $clog2(MK2) : 1;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int KW      = $clog2(MAX_KERNEL + 1);
    localparam int LB_ROWS = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
    localparam int SLOT_W  = (LB_ROWS > 1) ? $clog2(LB_ROWS) : 1;
    localparam int LB_W    = LB_ROWS * PIXEL_BITS;

    // configuration
    logic [CFG_BITS-1:0]   width_reg;
    logic [CFG_BITS-1:0]   height_reg;
    logic [KSIZE_BITS-1:0] ksize_reg;
    logic [COL_W:0]        w_eff;
    logic [COORD_BITS:0]   h_eff;
    logic [KW-1:0]         k_eff;

    // pixel position
    logic [COORD_BITS-1:0] row_reg, row_next;
    logic [COL_W-1:0]      col_reg, col_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;

    logic adv;
    logic in_acc;
    logic s0_produce;
    logic s0_last;

    // stage a: ram data returns
    logic                         a_valid_reg;
    logic                         a_pix_reg;
    logic                         a_produce_reg;
    logic                         a_last_reg;
    logic [COORD_BITS-1:0]        a_orow_reg;
    logic [COORD_BITS-1:0]        a_ocol_reg;
    logic [COORD_BITS-1:0]        a_prow_reg;
    logic [COL_W-1:0]             a_addr_reg;
    logic [SLOT_W-1:0]            a_slot_reg;
    logic [CIDX_W-1:0]            a_idx_reg;
    logic signed [PIXEL_BITS-1:0] a_value_reg;

    logic              fwd_reg;
    logic [LB_W-1:0]   fwd_word_reg;
    logic [LB_W-1:0]   rd_data;
    logic [LB_W-1:0]   lb_cur;
    logic [LB_W-1:0]   lb_wr_word;
    logic              ram_we;

    logic signed [PIXEL_BITS-1:0] kernel_reg [MK2];
    logic signed [PIXEL_BITS-1:0] win_reg    [MAX_KERNEL][MAX_KERNEL];
    logic signed [PIXEL_BITS-1:0] win_next   [MAX_KERNEL][MAX_KERNEL];

    res_meta_t a_meta;
    res_meta_t res_meta;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = (COL_W+1)'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = (COL_W+1)'(MAX_WIDTH);
        else
            w_eff = (COL_W+1)'(width_reg);
        if (height_reg == '0)
            h_eff = (COORD_BITS+1)'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            h_eff = (COORD_BITS+1)'(MAX_HEIGHT);
        else
            h_eff = (COORD_BITS+1)'(height_reg);
        if (ksize_reg == '0)
            k_eff = KW'(1);
        else if (32'(ksize_reg) > MAX_KERNEL)
            k_eff = KW'(MAX_KERNEL);
        else
            k_eff = KW'(ksize_reg);
    end

    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;
    assign in_acc   = in_valid && !in_stall;

    assign s0_produce = (32'(row_reg) + 1 >= 32'(k_eff)) && (32'(col_reg) + 1 >= 32'(k_eff));
    assign s0_last    = (32'(row_reg) + 1 == 32'(h_eff)) && (32'(col_reg) + 1 == 32'(w_eff));

    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        slot_next = slot_reg;
        if (cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT
                       || cfg_index == REG_KSIZE))
        begin
            row_next  = '0;
            col_next  = '0;
            slot_next = '0;
        end
        else if (in_acc && cmd == CMD_PIXEL)
        begin
            if (32'(col_reg) + 1 >= 32'(w_eff))
            begin
                col_next = '0;
                if (32'(row_reg) + 1 >= 32'(h_eff))
                begin
                    row_next  = '0;
                    slot_next = '0;
                end
                else
                begin
                    row_next  = row_reg + 1'b1;
                    slot_next = (32'(slot_reg) == LB_ROWS - 1) ? '0 : slot_reg + 1'b1;
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    v2cf_ram #(
        .WIDTH (LB_W),
        .DEPTH (MAX_WIDTH)
    ) u_lb_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (a_addr_reg),
        .wdata (lb_wr_word),
        .re    (in_acc && cmd == CMD_PIXEL),
        .raddr (col_reg),
        .rdata (rd_data)
    );

    assign lb_cur = fwd_reg ? fwd_word_reg : rd_data;
    assign ram_we = adv && a_valid_reg && a_pix_reg;

    always_comb
    begin
        lb_wr_word = lb_cur;
        lb_wr_word[a_slot_reg*PIXEL_BITS +: PIXEL_BITS] = a_value_reg;
    end

    // window shift and new right column
    always_comb
    begin
        int off;
        int s;
        off = MAX_KERNEL - int'(k_eff);
        for (int r = 0; r < MAX_KERNEL; r++)
        begin
            for (int c = 0; c < MAX_KERNEL - 1; c++)
            begin
                win_next[r][c] = win_reg[r][c+1];
            end
            win_next[r][MAX_KERNEL-1] = win_reg[r][MAX_KERNEL-1];
        end
        for (int r = 0; r < MAX_KERNEL; r++)
        begin
            s = int'(a_slot_reg) + 1 + r - int'(k_eff);
            if (s < 0)
                s = s + LB_ROWS;
            if (r < int'(k_eff))
            begin
                if (r == int'(k_eff) - 1)
                    win_next[off+r][MAX_KERNEL-1] = a_value_reg;
                else if (int'(a_prow_reg) + 1 + r >= int'(k_eff))
                    win_next[off+r][MAX_KERNEL-1] =
                        lb_cur[SLOT_W'(s)*PIXEL_BITS +: PIXEL_BITS];
                else
                    win_next[off+r][MAX_KERNEL-1] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= CFG_BITS'(1024);
            height_reg  <= CFG_BITS'(1024);
            ksize_reg   <= KSIZE_BITS'(3);
            row_reg     <= '0;
            col_reg     <= '0;
            slot_reg    <= '0;
            a_valid_reg <= 1'b0;
            fwd_reg     <= 1'b0;
            for (int i = 0; i < MK2; i++)
            begin
                kernel_reg[i] <= '0;
            end
        end
        else
        begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            slot_reg <= slot_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_WIDTH:  width_reg  <= cfg_data;
                    REG_HEIGHT: height_reg <= cfg_data;
                    REG_KSIZE:  ksize_reg  <= cfg_data[KSIZE_BITS-1:0];
                    default:    ;
                endcase
            end
            if (adv)
            begin
                a_valid_reg <= in_acc;
                if (a_valid_reg && !a_pix_reg && 32'(a_idx_reg) < MK2)
                begin
                    kernel_reg[a_idx_reg] <= a_value_reg;
                end
            end
            if (in_acc)
            begin
                fwd_reg <= ram_we && (a_addr_reg == col_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            a_pix_reg     <= (cmd == CMD_PIXEL);
            a_produce_reg <= s0_produce;
            a_last_reg    <= s0_last;
            a_orow_reg    <= COORD_BITS'(32'(row_reg) + 1 - 32'(k_eff));
            a_ocol_reg    <= COORD_BITS'(32'(col_reg) + 1 - 32'(k_eff));
            a_prow_reg    <= row_reg;
            a_addr_reg    <= col_reg;
            a_slot_reg    <= slot_reg;
            a_idx_reg     <= coef_index;
            a_value_reg   <= value;
            fwd_word_reg  <= lb_wr_word;
        end
        if (ram_we)
        begin
            win_reg <= win_next;
        end
    end

    always_comb
    begin
        a_meta.valid      = a_valid_reg && a_pix_reg && a_produce_reg;
        a_meta.out_row    = a_orow_reg;
        a_meta.out_col    = a_ocol_reg;
        a_meta.frame_last = a_last_reg;
    end

    v2cf_mac #(
        .MAX_KERNEL (MAX_KERNEL),
        .PIXEL_BITS (PIXEL_BITS),
        .KW         (KW)
    ) u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .meta_in  (a_meta),
        .k_eff    (k_eff),
        .kernel   (kernel_reg),
        .window   (win_reg),
        .sum      (sum),
        .meta_out (res_meta)
    );

    assign out_valid  = res_meta.valid;
    assign out_row    = res_meta.out_row;
    assign out_col    = res_meta.out_col;
    assign frame_last = res_meta.frame_last;

    a_cfg_clears_position: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT
                   || cfg_index == REG_KSIZE) |=> row_reg == '0 && col_reg == '0)
        else $error("position not cleared after register write");

    a_fwd_on_collision: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && ram_we && a_addr_reg == col_reg |=> fwd_reg)
        else $error("same-column read and write not forwarded");

    a_coef_written: assert property (@(posedge clk) disable iff (!rst_n)
        adv && a_valid_reg && !a_pix_reg && 32'(a_idx_reg) < MK2
        |=> kernel_reg[$past(a_idx_reg)] == $past(a_value_reg))
        else $error("coefficient load lost");

endmodule
